// File: hw/rtl/her_pkg.sv
`timescale 1ns / 1ps
// her_pkg: shared types, constants and the entity name ROM for the entity resolver.
// Depends on nothing; her_match and html_entity_resolver_unit import it.
package her_pkg;

    localparam int DEF_MAX_NAME_LEN        = 16;
    localparam int DEF_INSENSITIVE_ENTRIES = 126;
    localparam int ENT_COUNT               = 255;
    localparam int ENT_IDX_W               = 8;
    localparam int CMP_LANES               = 8;
    localparam int CHAR_W                  = 7;

    localparam logic [1:0] KIND_NAMED    = 2'd0;
    localparam logic [1:0] KIND_NUMERIC  = 2'd1;
    localparam logic [1:0] KIND_NOTFOUND = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [15:0] CODE_NOTFOUND = 16'd32;
    localparam logic [6:0]  CHAR_HASH     = 7'h23;
    localparam logic [15:0] CHAR_LX       = 16'h0078;
    localparam logic [15:0] CHAR_UX       = 16'h0058;

    // Table entry: name left aligned, first character in the top byte.
    typedef struct packed {
        logic [63:0] nm;
        logic [3:0]  len;
        logic [15:0] cp;
    } ent_t;

    function automatic ent_t mk(input logic [63:0] s, input logic [15:0] c);
        ent_t       e;
        logic [3:0] n;
        logic [6:0] sh;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (s[8*k +: 8] != 8'd0)
            begin
                n = n + 4'd1;
            end
        end
        sh = {3'd0, 4'd8 - n} << 3;
        e.nm = s << sh;
        e.len = n;
        e.cp = c;
        return e;
    endfunction

    function automatic ent_t ent_rom(input logic [ENT_IDX_W-1:0] idx);
        ent_t e;
        case (idx)
            8'd0: e = mk("AElig", 16'd198);     8'd1: e = mk("Aacute", 16'd193);
            8'd2: e = mk("Acirc", 16'd194);     8'd3: e = mk("Agrave", 16'd192);
            8'd4: e = mk("Alpha", 16'd913);     8'd5: e = mk("Aring", 16'd197);
            8'd6: e = mk("Atilde", 16'd195);    8'd7: e = mk("Auml", 16'd196);
            8'd8: e = mk("Beta", 16'd914);      8'd9: e = mk("Ccedil", 16'd199);
            8'd10: e = mk("Chi", 16'd935);      8'd11: e = mk("Dagger", 16'd8225);
            8'd12: e = mk("Delta", 16'd916);    8'd13: e = mk("ETH", 16'd208);
            8'd14: e = mk("Eacute", 16'd201);   8'd15: e = mk("Ecirc", 16'd202);
            8'd16: e = mk("Egrave", 16'd200);   8'd17: e = mk("Epsilon", 16'd917);
            8'd18: e = mk("Eta", 16'd919);      8'd19: e = mk("Euml", 16'd203);
            8'd20: e = mk("Gamma", 16'd915);    8'd21: e = mk("Iacute", 16'd205);
            8'd22: e = mk("Icirc", 16'd206);    8'd23: e = mk("Igrave", 16'd204);
            8'd24: e = mk("Iota", 16'd921);     8'd25: e = mk("Iuml", 16'd207);
            8'd26: e = mk("Kappa", 16'd922);    8'd27: e = mk("Lambda", 16'd923);
            8'd28: e = mk("Mu", 16'd924);       8'd29: e = mk("Ntilde", 16'd209);
            8'd30: e = mk("Nu", 16'd925);       8'd31: e = mk("OElig", 16'd338);
            8'd32: e = mk("Oacute", 16'd211);   8'd33: e = mk("Ocirc", 16'd212);
            8'd34: e = mk("Ograve", 16'd210);   8'd35: e = mk("Omega", 16'd937);
            8'd36: e = mk("Omicron", 16'd927);  8'd37: e = mk("Oslash", 16'd216);
            8'd38: e = mk("Otilde", 16'd213);   8'd39: e = mk("Ouml", 16'd214);
            8'd40: e = mk("Phi", 16'd934);      8'd41: e = mk("Pi", 16'd928);
            8'd42: e = mk("Prime", 16'd8243);   8'd43: e = mk("Psi", 16'd936);
            8'd44: e = mk("Rho", 16'd929);      8'd45: e = mk("Scaron", 16'd352);
            8'd46: e = mk("Sigma", 16'd931);    8'd47: e = mk("THORN", 16'd222);
            8'd48: e = mk("Tau", 16'd932);      8'd49: e = mk("Theta", 16'd920);
            8'd50: e = mk("Uacute", 16'd218);   8'd51: e = mk("Ucirc", 16'd219);
            8'd52: e = mk("Ugrave", 16'd217);   8'd53: e = mk("Upsilon", 16'd933);
            8'd54: e = mk("Uuml", 16'd220);     8'd55: e = mk("Xi", 16'd926);
            8'd56: e = mk("Yacute", 16'd221);   8'd57: e = mk("Yuml", 16'd376);
            8'd58: e = mk("Zeta", 16'd918);     8'd59: e = mk("aacute", 16'd225);
            8'd60: e = mk("acirc", 16'd226);    8'd61: e = mk("acute", 16'd180);
            8'd62: e = mk("aelig", 16'd230);    8'd63: e = mk("agrave", 16'd224);
            8'd64: e = mk("alpha", 16'd945);    8'd65: e = mk("atilde", 16'd227);
            8'd66: e = mk("auml", 16'd228);     8'd67: e = mk("beta", 16'd946);
            8'd68: e = mk("ccedil", 16'd231);   8'd69: e = mk("chi", 16'd967);
            8'd70: e = mk("dArr", 16'd8659);    8'd71: e = mk("dagger", 16'd8224);
            8'd72: e = mk("darr", 16'd8595);    8'd73: e = mk("delta", 16'd948);
            8'd74: e = mk("eacute", 16'd233);   8'd75: e = mk("ecirc", 16'd234);
            8'd76: e = mk("egrave", 16'd232);   8'd77: e = mk("epsilon", 16'd949);
            8'd78: e = mk("eta", 16'd951);      8'd79: e = mk("euml", 16'd235);
            8'd80: e = mk("gamma", 16'd947);    8'd81: e = mk("hArr", 16'd8660);
            8'd82: e = mk("harr", 16'd8596);    8'd83: e = mk("iacute", 16'd237);
            8'd84: e = mk("icirc", 16'd238);    8'd85: e = mk("igrave", 16'd236);
            8'd86: e = mk("iota", 16'd953);     8'd87: e = mk("iuml", 16'd239);
            8'd88: e = mk("kappa", 16'd954);    8'd89: e = mk("lArr", 16'd8656);
            8'd90: e = mk("lambda", 16'd955);   8'd91: e = mk("larr", 16'd8592);
            8'd92: e = mk("mu", 16'd956);       8'd93: e = mk("ntilde", 16'd241);
            8'd94: e = mk("nu", 16'd957);       8'd95: e = mk("oacute", 16'd243);
            8'd96: e = mk("ocirc", 16'd244);    8'd97: e = mk("oelig", 16'd339);
            8'd98: e = mk("ograve", 16'd242);   8'd99: e = mk("omega", 16'd969);
            8'd100: e = mk("omicron", 16'd959); 8'd101: e = mk("oslash", 16'd248);
            8'd102: e = mk("otilde", 16'd245);  8'd103: e = mk("otimes", 16'd8855);
            8'd104: e = mk("ouml", 16'd246);    8'd105: e = mk("phi", 16'd966);
            8'd106: e = mk("pi", 16'd960);      8'd107: e = mk("psi", 16'd968);
            8'd108: e = mk("rArr", 16'd8658);   8'd109: e = mk("rarr", 16'd8594);
            8'd110: e = mk("rho", 16'd961);     8'd111: e = mk("scaron", 16'd353);
            8'd112: e = mk("sigma", 16'd963);   8'd113: e = mk("tau", 16'd964);
            8'd114: e = mk("theta", 16'd952);   8'd115: e = mk("thorn", 16'd254);
            8'd116: e = mk("uArr", 16'd8657);   8'd117: e = mk("uacute", 16'd250);
            8'd118: e = mk("uarr", 16'd8593);   8'd119: e = mk("ucirc", 16'd251);
            8'd120: e = mk("ugrave", 16'd249);  8'd121: e = mk("upsilon", 16'd965);
            8'd122: e = mk("uuml", 16'd252);    8'd123: e = mk("xi", 16'd958);
            8'd124: e = mk("yacute", 16'd253);  8'd125: e = mk("yuml", 16'd255);
            8'd126: e = mk("zeta", 16'd950);    8'd127: e = mk("zwj", 16'd8205);
            8'd128: e = mk("zwnj", 16'd8204);   8'd129: e = mk("alefsym", 16'd8501);
            8'd130: e = mk("amp", 16'd38);      8'd131: e = mk("and", 16'd8743);
            8'd132: e = mk("ang", 16'd8736);    8'd133: e = mk("apos", 16'd39);
            8'd134: e = mk("aring", 16'd229);   8'd135: e = mk("asymp", 16'd8776);
            8'd136: e = mk("bdquo", 16'd8222);  8'd137: e = mk("brvbar", 16'd166);
            8'd138: e = mk("bull", 16'd8226);   8'd139: e = mk("cap", 16'd8745);
            8'd140: e = mk("cedil", 16'd184);   8'd141: e = mk("cent", 16'd162);
            8'd142: e = mk("circ", 16'd710);    8'd143: e = mk("clubs", 16'd9827);
            8'd144: e = mk("cong", 16'd8773);   8'd145: e = mk("copy", 16'd169);
            8'd146: e = mk("crarr", 16'd8629);  8'd147: e = mk("cup", 16'd8746);
            8'd148: e = mk("curren", 16'd164);  8'd149: e = mk("deg", 16'd176);
            8'd150: e = mk("diams", 16'd9830);  8'd151: e = mk("divide", 16'd247);
            8'd152: e = mk("empty", 16'd8709);  8'd153: e = mk("emsp", 16'd8195);
            8'd154: e = mk("ensp", 16'd8194);   8'd155: e = mk("equiv", 16'd8801);
            8'd156: e = mk("eth", 16'd240);     8'd157: e = mk("euro", 16'd8364);
            8'd158: e = mk("exist", 16'd8707);  8'd159: e = mk("fnof", 16'd402);
            8'd160: e = mk("forall", 16'd8704); 8'd161: e = mk("frac12", 16'd189);
            8'd162: e = mk("frac14", 16'd188);  8'd163: e = mk("frac34", 16'd190);
            8'd164: e = mk("frasl", 16'd8260);  8'd165: e = mk("ge", 16'd8805);
            8'd166: e = mk("gt", 16'd62);       8'd167: e = mk("hearts", 16'd9829);
            8'd168: e = mk("hellip", 16'd8230); 8'd169: e = mk("iexcl", 16'd161);
            8'd170: e = mk("image", 16'd8465);  8'd171: e = mk("infin", 16'd8734);
            8'd172: e = mk("int", 16'd8747);    8'd173: e = mk("iquest", 16'd191);
            8'd174: e = mk("isin", 16'd8712);   8'd175: e = mk("lang", 16'd9001);
            8'd176: e = mk("laquo", 16'd171);   8'd177: e = mk("lceil", 16'd8968);
            8'd178: e = mk("ldquo", 16'd8220);  8'd179: e = mk("le", 16'd8804);
            8'd180: e = mk("lfloor", 16'd8970); 8'd181: e = mk("lowast", 16'd8727);
            8'd182: e = mk("loz", 16'd9674);    8'd183: e = mk("lrm", 16'd8206);
            8'd184: e = mk("lsaquo", 16'd8249); 8'd185: e = mk("lsquo", 16'd8216);
            8'd186: e = mk("lt", 16'd60);       8'd187: e = mk("macr", 16'd175);
            8'd188: e = mk("mdash", 16'd8212);  8'd189: e = mk("micro", 16'd181);
            8'd190: e = mk("middot", 16'd183);  8'd191: e = mk("minus", 16'd8722);
            8'd192: e = mk("nabla", 16'd8711);  8'd193: e = mk("nbsp", 16'd160);
            8'd194: e = mk("ndash", 16'd8211);  8'd195: e = mk("ne", 16'd8800);
            8'd196: e = mk("ni", 16'd8715);     8'd197: e = mk("not", 16'd172);
            8'd198: e = mk("notin", 16'd8713);  8'd199: e = mk("nsub", 16'd8836);
            8'd200: e = mk("oline", 16'd8254);  8'd201: e = mk("oplus", 16'd8853);
            8'd202: e = mk("or", 16'd8744);     8'd203: e = mk("ordf", 16'd170);
            8'd204: e = mk("ordm", 16'd186);    8'd205: e = mk("para", 16'd182);
            8'd206: e = mk("part", 16'd8706);   8'd207: e = mk("permil", 16'd8240);
            8'd208: e = mk("perp", 16'd8869);   8'd209: e = mk("piv", 16'd982);
            8'd210: e = mk("plusmn", 16'd177);  8'd211: e = mk("pound", 16'd163);
            8'd212: e = mk("prime", 16'd8242);  8'd213: e = mk("prod", 16'd8719);
            8'd214: e = mk("prop", 16'd8733);   8'd215: e = mk("quot", 16'd34);
            8'd216: e = mk("radic", 16'd8730);  8'd217: e = mk("rang", 16'd9002);
            8'd218: e = mk("raquo", 16'd187);   8'd219: e = mk("rceil", 16'd8969);
            8'd220: e = mk("rdquo", 16'd8221);  8'd221: e = mk("real", 16'd8476);
            8'd222: e = mk("reg", 16'd174);     8'd223: e = mk("rfloor", 16'd8971);
            8'd224: e = mk("rlm", 16'd8207);    8'd225: e = mk("rsaquo", 16'd8250);
            8'd226: e = mk("rsquo", 16'd8217);  8'd227: e = mk("sbquo", 16'd8218);
            8'd228: e = mk("sdot", 16'd8901);   8'd229: e = mk("sect", 16'd167);
            8'd230: e = mk("shy", 16'd173);     8'd231: e = mk("sigmaf", 16'd962);
            8'd232: e = mk("sim", 16'd8764);    8'd233: e = mk("spades", 16'd9824);
            8'd234: e = mk("sub", 16'd8834);    8'd235: e = mk("sube", 16'd8838);
            8'd236: e = mk("sum", 16'd8721);    8'd237: e = mk("sup", 16'd8835);
            8'd238: e = mk("sup1", 16'd185);    8'd239: e = mk("sup2", 16'd178);
            8'd240: e = mk("sup3", 16'd179);    8'd241: e = mk("supe", 16'd8839);
            8'd242: e = mk("szlig", 16'd223);   8'd243: e = mk("there4", 16'd8756);
            8'd244: e = mk("thetasym", 16'd977); 8'd245: e = mk("thinsp", 16'd8201);
            8'd246: e = mk("tilde", 16'd732);   8'd247: e = mk("times", 16'd215);
            8'd248: e = mk("trade", 16'd8482);  8'd249: e = mk("uml", 16'd168);
            8'd250: e = mk("upsih", 16'd978);   8'd251: e = mk("weierp", 16'd8472);
            8'd252: e = mk("yen", 16'd165);     8'd253: e = mk("zwj", 16'd8205);
            8'd254: e = mk("zwnj", 16'd8204);
            default: e = mk(64'd0, 16'd0);
        endcase
        return e;
    endfunction

endpackage

// File: hw/rtl/her_if.sv
`timescale 1ns / 1ps
// her_in_if / her_out_if: valid/ready channels for entity characters and resolved codes.
// Depends on nothing.
interface her_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        has_char;
    logic        last;
    modport source (output valid, char_code, has_char, last, input ready);
    modport sink   (input valid, char_code, has_char, last, output ready);
endinterface

interface her_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic [1:0]  result_kind;
    modport source (output valid, code_point, result_kind, input ready);
    modport sink   (input valid, code_point, result_kind, output ready);
endinterface

// File: hw/rtl/her_match.sv
`timescale 1ns / 1ps
// her_match: shared name comparator, checks the buffered name against one table entry.
// Depends on her_pkg.
module her_match
    import her_pkg::*;
#(
    parameter int LEN_W = 5
)(
    input  logic [CHAR_W-1:0] name [CMP_LANES],
    input  logic [LEN_W-1:0]  name_len,
    input  ent_t              entry,
    input  logic              nocase,
    output logic              match
);

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return (c >= 7'h41 && c <= 7'h5A) ? c + 7'd32 : c;
    endfunction

    logic [CMP_LANES-1:0] lane_ok;

    // Compare each lane; lanes past the entry length do not count
    always_comb
    begin
        for (int i = 0; i < CMP_LANES; i++)
        begin
            logic [CHAR_W-1:0] t;
            t = entry.nm[62-8*i -: CHAR_W];
            if (4'(i) >= entry.len)
            begin
                lane_ok[i] = 1'b1;
            end
            else if (nocase)
            begin
                lane_ok[i] = (fold(name[i]) == fold(t));
            end
            else
            begin
                lane_ok[i] = (name[i] == t);
            end
        end
    end

    assign match = (name_len == LEN_W'(entry.len)) && (&lane_ok);

endmodule

// File: hw/rtl/html_entity_resolver_unit.sv
`timescale 1ns / 1ps
// html_entity_resolver_unit: a last request goes through a resolve state, which settles
// numeric, empty or unmatchable names directly and otherwise starts a table lookup, where the
// comparator steps through entries 0..254, one per cycle.
// Not ready while resolving; the result register frees the input once loaded.
// Reset (asynchronous, active low) empties the name and drops any pending result.
module html_entity_resolver_unit
    import her_pkg::*;
#(
    parameter int MAX_NAME_LEN        = DEF_MAX_NAME_LEN,
    parameter int INSENSITIVE_ENTRIES = DEF_INSENSITIVE_ENTRIES
)(
    input  logic     clk,
    input  logic     rst_n,
    her_in_if.sink   in_ch,
    her_out_if.source out_ch
);

    localparam int LEN_W = $clog2(MAX_NAME_LEN + 1);
    localparam int POS_W = $clog2(MAX_NAME_LEN);
    localparam int SPLIT = (INSENSITIVE_ENTRIES > ENT_COUNT) ? 0
                         : ENT_COUNT - INSENSITIVE_ENTRIES;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RESOLVE = 2'd1;
    localparam logic [1:0] ST_SCAN    = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CHAR_W-1:0]    name_store [MAX_NAME_LEN];
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 unm_reg, unm_next;
    logic [15:0]          val_reg, val_next;
    logic                 ovf_reg, ovf_next;
    logic                 dok_reg, dok_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic                 hex_reg, hex_next;
    logic [ENT_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]          res_code_reg, res_code_next;
    logic [1:0]           res_kind_reg, res_kind_next;
    logic                 ov_reg, ov_next;
    logic [15:0]          oc_reg, oc_next;
    logic [1:0]           ok_reg, ok_next;

    logic                 acc;
    logic                 store_we;
    logic [CHAR_W-1:0]    store_char;
    logic [CHAR_W-1:0]    lane_name [CMP_LANES];
    ent_t                 entry;
    logic                 match;
    logic [15:0]          c;
    logic                 is_dec, is_lhex, is_uhex;
    logic [3:0]           dig;
    logic [19:0]          acc_val;

    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign c = in_ch.char_code;

    // Decode a digit of the current radix
    assign is_dec  = (c >= 16'h0030) && (c <= 16'h0039);
    assign is_lhex = hex_reg && (c >= 16'h0061) && (c <= 16'h0066);
    assign is_uhex = hex_reg && (c >= 16'h0041) && (c <= 16'h0046);
    assign dig = is_dec  ? 4'(c - 16'h0030)
               : is_lhex ? 4'(c - 16'h0057)
               :           4'(c - 16'h0037);
    assign acc_val = hex_reg ? ({4'd0, val_reg} << 4) + {16'd0, dig}
                   : ({4'd0, val_reg} << 3) + ({4'd0, val_reg} << 1) + {16'd0, dig};

    // Feed the comparator with the first lanes of the name and the current entry
    always_comb
    begin
        for (int i = 0; i < CMP_LANES; i++)
        begin
            lane_name[i] = name_store[i];
        end
    end
    assign entry = ent_rom(idx_reg);

    her_match #(.LEN_W(LEN_W)) u_match (
        .name     (lane_name),
        .name_len (len_reg),
        .entry    (entry),
        .nocase   ({1'b0, idx_reg} >= 9'(SPLIT)),
        .match    (match)
    );

    assign store_we = acc && in_ch.has_char && (len_reg < LEN_W'(MAX_NAME_LEN));
    assign store_char = (c < 16'd128) ? c[CHAR_W-1:0] : '0;

    // Sequencer: collect characters, resolve, scan table, hand off result
    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        unm_next = unm_reg;
        val_next = val_reg;
        ovf_next = ovf_reg;
        dok_next = dok_reg;
        cnt_next = cnt_reg;
        hex_next = hex_reg;
        idx_next = idx_reg;
        res_code_next = res_code_reg;
        res_kind_next = res_kind_reg;
        ov_next = ov_reg && !out_ch.ready;
        oc_next = oc_reg;
        ok_next = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && in_ch.has_char)
                begin
                    if (c >= 16'd128)
                    begin
                        unm_next = 1'b1;
                    end
                    if (len_reg < LEN_W'(MAX_NAME_LEN))
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        unm_next = 1'b1;
                    end
                    if (len_reg >= LEN_W'(1) && name_store[0] == CHAR_HASH)
                    begin
                        if (len_reg == LEN_W'(1) && (c == CHAR_LX || c == CHAR_UX))
                        begin
                            hex_next = 1'b1;
                        end
                        else if (dok_reg)
                        begin
                            if (is_dec || is_lhex || is_uhex)
                            begin
                                if (!ovf_reg)
                                begin
                                    if (acc_val > 20'd65535)
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else
                                    begin
                                        val_next = acc_val[15:0];
                                    end
                                end
                                if (cnt_reg != 5'd31)
                                begin
                                    cnt_next = cnt_reg + 5'd1;
                                end
                            end
                            else
                            begin
                                dok_next = 1'b0;
                            end
                        end
                    end
                end
                if (acc && in_ch.last)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                state_next = ST_DONE;
                idx_next = '0;
                if (len_reg == '0)
                begin
                    res_code_next = 16'd0;
                    res_kind_next = KIND_ERROR;
                end
                else if (len_reg >= LEN_W'(2) && name_store[0] == CHAR_HASH
                         && len_reg > (hex_reg ? LEN_W'(2) : LEN_W'(1)))
                begin
                    if (cnt_reg == 5'd0 || ovf_reg)
                    begin
                        res_code_next = 16'd0;
                        res_kind_next = KIND_ERROR;
                    end
                    else
                    begin
                        res_code_next = val_reg;
                        res_kind_next = KIND_NUMERIC;
                    end
                end
                else if (unm_reg)
                begin
                    res_code_next = CODE_NOTFOUND;
                    res_kind_next = KIND_NOTFOUND;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    res_code_next = entry.cp;
                    res_kind_next = KIND_NAMED;
                    state_next = ST_DONE;
                end
                else if (idx_reg == ENT_IDX_W'(ENT_COUNT - 1))
                begin
                    res_code_next = CODE_NOTFOUND;
                    res_kind_next = KIND_NOTFOUND;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    oc_next = res_code_reg;
                    ok_next = res_kind_reg;
                    len_next = '0;
                    unm_next = 1'b0;
                    val_next = 16'd0;
                    ovf_next = 1'b0;
                    dok_next = 1'b1;
                    cnt_next = 5'd0;
                    hex_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            unm_reg <= 1'b0;
            val_reg <= 16'd0;
            ovf_reg <= 1'b0;
            dok_reg <= 1'b1;
            cnt_reg <= 5'd0;
            hex_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            unm_reg <= unm_next;
            val_reg <= val_next;
            ovf_reg <= ovf_next;
            dok_reg <= dok_next;
            cnt_reg <= cnt_next;
            hex_reg <= hex_next;
            ov_reg <= ov_next;
        end
    end

    // Hold payload: name buffer, scan index, result
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            name_store[len_reg[POS_W-1:0]] <= store_char;
        end
        idx_reg <= idx_next;
        res_code_reg <= res_code_next;
        res_kind_reg <= res_kind_next;
        oc_reg <= oc_next;
        ok_reg <= ok_next;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.code_point = oc_reg;
    assign out_ch.result_kind = ok_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ok_reg == KIND_ERROR) |-> oc_reg == 16'd0)
        else $error("error result with nonzero code");
    a_nf_space: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ok_reg == KIND_NOTFOUND) |-> oc_reg == CODE_NOTFOUND)
        else $error("not-found result with wrong code");
    a_last_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_ch.last) |=> state_reg == ST_RESOLVE)
        else $error("last request did not start resolution");
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_DONE))
        else $error("scan left to wrong state");
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> (len_reg == '0 && ov_reg))
        else $error("name not cleared on result load");

endmodule

// File: verif/html_entity_resolver_unit_tb.sv
`timescale 1ns / 1ps
// html_entity_resolver_unit_tb: streams entity names into the resolver and checks every code.
// Depends on her_pkg, the her_in_if / her_out_if channels and html_entity_resolver_unit.
module html_entity_resolver_unit_tb;
    import her_pkg::*;

    localparam int NAME_CAP    = 16;
    localparam int NOCASE_FROM = ENT_COUNT - DEF_INSENSITIVE_ENTRIES;
    localparam int CALM_TAIL   = 80;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [15:0] ch;
        logic        has;
        logic        fin;
    } char_req_t;

    typedef struct {
        logic [15:0] code;
        logic [1:0]  kind;
    } code_res_t;

    logic clk;
    logic rst_n;
    her_in_if  in_ch();
    her_out_if out_ch();

    html_entity_resolver_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Entity names with their code points, in ROM order
    string ent_txt [ENT_COUNT] = '{
        "AElig 198", "Aacute 193", "Acirc 194", "Agrave 192", "Alpha 913",
        "Aring 197", "Atilde 195", "Auml 196", "Beta 914", "Ccedil 199",
        "Chi 935", "Dagger 8225", "Delta 916", "ETH 208", "Eacute 201",
        "Ecirc 202", "Egrave 200", "Epsilon 917", "Eta 919", "Euml 203",
        "Gamma 915", "Iacute 205", "Icirc 206", "Igrave 204", "Iota 921",
        "Iuml 207", "Kappa 922", "Lambda 923", "Mu 924", "Ntilde 209",
        "Nu 925", "OElig 338", "Oacute 211", "Ocirc 212", "Ograve 210",
        "Omega 937", "Omicron 927", "Oslash 216", "Otilde 213", "Ouml 214",
        "Phi 934", "Pi 928", "Prime 8243", "Psi 936", "Rho 929",
        "Scaron 352", "Sigma 931", "THORN 222", "Tau 932", "Theta 920",
        "Uacute 218", "Ucirc 219", "Ugrave 217", "Upsilon 933", "Uuml 220",
        "Xi 926", "Yacute 221", "Yuml 376", "Zeta 918", "aacute 225",
        "acirc 226", "acute 180", "aelig 230", "agrave 224", "alpha 945",
        "atilde 227", "auml 228", "beta 946", "ccedil 231", "chi 967",
        "dArr 8659", "dagger 8224", "darr 8595", "delta 948", "eacute 233",
        "ecirc 234", "egrave 232", "epsilon 949", "eta 951", "euml 235",
        "gamma 947", "hArr 8660", "harr 8596", "iacute 237", "icirc 238",
        "igrave 236", "iota 953", "iuml 239", "kappa 954", "lArr 8656",
        "lambda 955", "larr 8592", "mu 956", "ntilde 241", "nu 957",
        "oacute 243", "ocirc 244", "oelig 339", "ograve 242", "omega 969",
        "omicron 959", "oslash 248", "otilde 245", "otimes 8855", "ouml 246",
        "phi 966", "pi 960", "psi 968", "rArr 8658", "rarr 8594",
        "rho 961", "scaron 353", "sigma 963", "tau 964", "theta 952",
        "thorn 254", "uArr 8657", "uacute 250", "uarr 8593", "ucirc 251",
        "ugrave 249", "upsilon 965", "uuml 252", "xi 958", "yacute 253",
        "yuml 255", "zeta 950", "zwj 8205", "zwnj 8204",
        "alefsym 8501", "amp 38", "and 8743", "ang 8736", "apos 39",
        "aring 229", "asymp 8776", "bdquo 8222", "brvbar 166", "bull 8226",
        "cap 8745", "cedil 184", "cent 162", "circ 710", "clubs 9827",
        "cong 8773", "copy 169", "crarr 8629", "cup 8746", "curren 164",
        "deg 176", "diams 9830", "divide 247", "empty 8709", "emsp 8195",
        "ensp 8194", "equiv 8801", "eth 240", "euro 8364", "exist 8707",
        "fnof 402", "forall 8704", "frac12 189", "frac14 188", "frac34 190",
        "frasl 8260", "ge 8805", "gt 62", "hearts 9829", "hellip 8230",
        "iexcl 161", "image 8465", "infin 8734", "int 8747", "iquest 191",
        "isin 8712", "lang 9001", "laquo 171", "lceil 8968", "ldquo 8220",
        "le 8804", "lfloor 8970", "lowast 8727", "loz 9674", "lrm 8206",
        "lsaquo 8249", "lsquo 8216", "lt 60", "macr 175", "mdash 8212",
        "micro 181", "middot 183", "minus 8722", "nabla 8711", "nbsp 160",
        "ndash 8211", "ne 8800", "ni 8715", "not 172", "notin 8713",
        "nsub 8836", "oline 8254", "oplus 8853", "or 8744", "ordf 170",
        "ordm 186", "para 182", "part 8706", "permil 8240", "perp 8869",
        "piv 982", "plusmn 177", "pound 163", "prime 8242", "prod 8719",
        "prop 8733", "quot 34", "radic 8730", "rang 9002", "raquo 187",
        "rceil 8969", "rdquo 8221", "real 8476", "reg 174", "rfloor 8971",
        "rlm 8207", "rsaquo 8250", "rsquo 8217", "sbquo 8218", "sdot 8901",
        "sect 167", "shy 173", "sigmaf 962", "sim 8764", "spades 9824",
        "sub 8834", "sube 8838", "sum 8721", "sup 8835", "sup1 185",
        "sup2 178", "sup3 179", "supe 8839", "szlig 223", "there4 8756",
        "thetasym 977", "thinsp 8201", "tilde 732", "times 215", "trade 8482",
        "uml 168", "upsih 978", "weierp 8472", "yen 165", "zwj 8205",
        "zwnj 8204"
    };
    string ent_nm [ENT_COUNT];
    int    ent_cp [ENT_COUNT];

    // Predictor state for the name being assembled
    logic [6:0]  nm_chars [NAME_CAP];
    int unsigned nm_len;
    bit          nm_bad;
    int unsigned num_val;
    bit          num_ovf;
    bit          num_ok;
    int unsigned num_cnt;
    bit          num_hex;

    char_req_t   pending_chars[$];
    code_res_t   expected_codes[$];
    int          errors;
    int          cycles;
    int          gap_in;
    int          gap_out;
    bit          calm;

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void clear_name_state();
        nm_len  = 0;
        nm_bad  = 0;
        num_val = 0;
        num_ovf = 0;
        num_ok  = 1;
        num_cnt = 0;
        num_hex = 0;
    endfunction

    function automatic void take_digit(int unsigned c);
        int unsigned d;
        int unsigned nv;
        if (!num_ok)
            return;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (num_hex && c >= "a" && c <= "f")
            d = c - "a" + 10;
        else if (num_hex && c >= "A" && c <= "F")
            d = c - "A" + 10;
        else
        begin
            num_ok = 0;
            return;
        end
        if (!num_ovf)
        begin
            nv = num_val * (num_hex ? 16 : 10) + d;
            if (nv > 65535)
                num_ovf = 1;
            else
                num_val = nv;
        end
        if (num_cnt < 31)
            num_cnt++;
    endfunction

    function automatic void append_char(int unsigned c);
        int unsigned pos;
        pos = nm_len;
        if (c >= 128)
            nm_bad = 1;
        if (pos < NAME_CAP)
        begin
            nm_chars[pos] = (c < 128) ? c[6:0] : 7'd0;
            nm_len = pos + 1;
        end
        else
            nm_bad = 1;
        if (pos >= 1 && nm_chars[0] == CHAR_HASH)
        begin
            if (pos == 1 && (c == CHAR_LX || c == CHAR_UX))
                num_hex = 1;
            else
                take_digit(c);
        end
    endfunction

    function automatic bit name_hits(int e, bit nocase);
        string s;
        s = ent_nm[e];
        if (s.len() != nm_len)
            return 0;
        for (int i = 0; i < s.len(); i++)
        begin
            if (nocase ? (fold_case({1'b0, nm_chars[i]}) != fold_case(s[i]))
                       : ({1'b0, nm_chars[i]} != s[i]))
                return 0;
        end
        return 1;
    endfunction

    function automatic code_res_t resolve_name();
        code_res_t r;
        int unsigned prefix;
        r.code = CODE_NOTFOUND;
        r.kind = KIND_NOTFOUND;
        prefix = num_hex ? 2 : 1;
        if (nm_len == 0)
        begin
            r.code = 16'd0;
            r.kind = KIND_ERROR;
        end
        else if (nm_len >= 2 && nm_chars[0] == CHAR_HASH && nm_len > prefix)
        begin
            if (num_cnt == 0 || num_ovf)
            begin
                r.code = 16'd0;
                r.kind = KIND_ERROR;
            end
            else
            begin
                r.code = num_val[15:0];
                r.kind = KIND_NUMERIC;
            end
        end
        else if (!nm_bad)
        begin
            for (int e = 0; e < ENT_COUNT && r.kind == KIND_NOTFOUND; e++)
            begin
                if (name_hits(e, e >= NOCASE_FROM))
                begin
                    r.code = ent_cp[e][15:0];
                    r.kind = KIND_NAMED;
                end
            end
        end
        return r;
    endfunction

    // Update the name state for one accepted request; queue a code on last
    function automatic void predict_char(logic [15:0] ch, logic has, logic fin);
        if (has)
            append_char(ch);
        if (fin)
        begin
            expected_codes.push_back(resolve_name());
            clear_name_state();
        end
    endfunction

    task automatic push_req(logic [15:0] ch, logic has, logic fin);
        char_req_t r;
        r.ch  = ch;
        r.has = has;
        r.fin = fin;
        pending_chars.push_back(r);
    endtask

    // Queue a whole name, ended either on its last character or by a bare end mark
    task automatic push_name(string s, bit bare_end);
        for (int i = 0; i < s.len(); i++)
            push_req({8'd0, s[i]}, 1'b1, !bare_end && i == s.len() - 1);
        if (bare_end || s.len() == 0)
            push_req(16'($urandom), 1'b0, 1'b1);
    endtask

    task automatic push_random_name(ref int count);
        int    pick;
        int    n;
        string s;
        string t;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // table name, sometimes with case flips
            s = ent_nm[$urandom_range(0, ENT_COUNT - 1)];
            for (int i = 0; i < s.len(); i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    s[i] = (s[i] >= "a" && s[i] <= "z") ? s[i] - 8'd32
                         : (s[i] >= "A" && s[i] <= "Z") ? s[i] + 8'd32 : s[i];
            end
            if ($urandom_range(0, 9) == 0)
                s = s.substr(0, s.len() - 2);
            push_name(s, $urandom_range(0, 4) == 0);
            count += s.len() + 1;
        end
        else if (pick < 70)
        begin
            // numeric, decimal or hex, some past the top
            if ($urandom_range(0, 1))
                s = $sformatf("%0d", $urandom_range(0, $urandom_range(0, 1) ? 70000 : 300));
            else
            begin
                t = $sformatf("%0h", $urandom_range(0, $urandom_range(0, 1) ? 17'h1ffff : 255));
                if ($urandom_range(0, 1))
                    t = t.toupper();
                s = {($urandom_range(0, 1) ? "x" : "X"), t};
            end
            if ($urandom_range(0, 5) == 0)
                s = {"00", s};
            if ($urandom_range(0, 7) == 0)
                s = {s, "q7"};
            s = {"#", s};
            push_name(s, $urandom_range(0, 4) == 0);
            count += s.len() + 1;
        end
        else if (pick < 85)
        begin
            // random characters, any 16-bit value now and then
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if (i == 0 && $urandom_range(0, 3) == 0)
                    push_req({9'd0, CHAR_HASH}, 1'b1, n == 1);
                else if ($urandom_range(0, 3) == 0)
                    push_req(16'($urandom), 1'b1, i == n - 1);
                else
                    push_req(16'($urandom_range(0, 127)), 1'b1, i == n - 1);
            end
            count += n;
        end
        else if (pick < 92)
        begin
            // past the name buffer
            n = $urandom_range(NAME_CAP + 1, NAME_CAP + 4);
            s = ($urandom_range(0, 1)) ? "#" : "a";
            for (int i = 1; i < n; i++)
                s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            push_name(s, 1'b0);
            count += n;
        end
        else if (pick < 96)
        begin
            // noise: ignored by the block
            push_req(16'($urandom), 1'b0, 1'b0);
        end
        else
        begin
            push_name("", 1'b0);
            count += 1;
        end
    endtask

    // Generate 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Drive character requests from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.char_code <= 16'd0;
            in_ch.has_char  <= 1'b0;
            in_ch.last      <= 1'b0;
            gap_in          <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_char(in_ch.char_code, in_ch.has_char, in_ch.last);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_in > 0)
                begin
                    gap_in      <= gap_in - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_chars.size() > 0 && !calm && $urandom_range(0, 11) == 0)
                begin
                    gap_in      <= $urandom_range(1, 18);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    in_ch.char_code <= pending_chars[0].ch;
                    in_ch.has_char  <= pending_chars[0].has;
                    in_ch.last      <= pending_chars[0].fin;
                    in_ch.valid     <= 1'b1;
                    void'(pending_chars.pop_front());
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Accept codes with random stalls and check them against the expected queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            gap_out      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    $display("%0t: unexpected code expected none actual code=%0d kind=%0d",
                             $time, out_ch.code_point, out_ch.result_kind);
                    errors++;
                end
                else
                begin
                    if (out_ch.code_point !== expected_codes[0].code)
                    begin
                        $display("%0t: code_point expected %0d actual %0d", $time,
                                 expected_codes[0].code, out_ch.code_point);
                        errors++;
                    end
                    if (out_ch.result_kind !== expected_codes[0].kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d", $time,
                                 expected_codes[0].kind, out_ch.result_kind);
                        errors++;
                    end
                    void'(expected_codes.pop_front());
                end
            end
            if (gap_out > 0)
            begin
                gap_out      <= gap_out - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap_out      <= $urandom_range(1, 18);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int    count;
        string nm;
        int    cp;
        errors = 0;
        cycles = 0;
        calm   = 0;
        count  = 0;
        rst_n  = 1'b0;
        for (int e = 0; e < ENT_COUNT; e++)
        begin
            void'($sscanf(ent_txt[e], "%s %d", nm, cp));
            ent_nm[e] = nm;
            ent_cp[e] = cp;
        end
        clear_name_state();

        // Directed names: table halves, numeric edges, empty and broken names
        push_name("amp", 1'b0);
        push_name("AMP", 1'b0);
        push_name("Alpha", 1'b0);
        push_name("ALPHA", 1'b1);
        push_name("thetasym", 1'b0);
        push_name("zwnj", 1'b0);
        push_name("#65", 1'b0);
        push_name("#x41", 1'b1);
        push_name("#XfFfF", 1'b0);
        push_name("#65535", 1'b0);
        push_name("#65536", 1'b0);
        push_name("#", 1'b0);
        push_name("#x", 1'b1);
        push_name("#X", 1'b0);
        push_name("#q1", 1'b0);
        push_name("#0000000000000065", 1'b0);
        push_name("abcdefghijklmnopq", 1'b0);
        push_name("", 1'b0);
        push_req(16'hffff, 1'b0, 1'b0);
        push_req({8'd0, "l"}, 1'b1, 1'b0);
        push_req(16'hffff, 1'b1, 1'b0);
        push_req({8'd0, "t"}, 1'b1, 1'b1);
        push_req(16'd0, 1'b1, 1'b1);
        push_req(16'h00e9, 1'b1, 1'b1);

        // Random names
        while (count < 650)
            push_random_name(count);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_chars.size() < CALM_TAIL);
        calm = 1;
        wait (pending_chars.size() == 0);
        @(posedge clk);
        while (in_ch.valid)
            @(posedge clk);
        while (expected_codes.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/her_pkg.sv
hw/rtl/her_if.sv
hw/rtl/her_match.sv
hw/rtl/html_entity_resolver_unit.sv
verif/html_entity_resolver_unit_tb.sv
